// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files, included by the top-level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre implies post in the same cycle
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// pre implies post in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// cond never holds
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/ctpg_pkg.sv =====
`default_nettype none

package ctpg_pkg;

  // Field widths
  localparam int TICK_W     = 48;
  localparam int TPS_W      = 24;
  localparam int BPB_W      = 7;
  localparam int LEVEL_W    = 16;
  localparam int LEN_W      = 8;
  localparam int GAPCFG_W   = 24;
  localparam int TICKNUM_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Bar length in whole ticks: beats_per_bar * 24 fits in 12 bits
  localparam int MOD_W             = 12;
  localparam int TICKS_PER_QUARTER = 24;

  // Error window is 20 samples worth of tick advance
  localparam int ERR_W         = 29;
  localparam int ERROR_SAMPLES = 20;

  localparam logic [LEVEL_W-1:0] HOLD_LEVEL = 16'd58982;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP      = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0]    PULSE_LENGTH_RST = 8'd24;
  localparam logic [GAPCFG_W-1:0] MIN_GAP_RST      = 24'd299;
  localparam logic [GAPCFG_W-1:0] MAX_GAP_RST      = 24'd4013;

  // Controller to datapath
  typedef struct packed {
    logic load;   // latch a new request and arm the remainder unit
    logic step;   // one remainder iteration
    logic exec;   // commit state and load the result register
  } ctpg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // current step is the last remainder iteration
  } ctpg_status_t;

  // Rising ramp: (HOLD * k + 2) / 4 for k of 1..3
  function automatic logic [LEVEL_W-1:0] ramp_up_level(input logic [1:0] k);
    logic [LEVEL_W-1:0] lv;
    unique case (k)
      2'd1:    lv = 16'd14746;
      2'd2:    lv = 16'd29491;
      2'd3:    lv = 16'd44237;
      default: lv = '0;
    endcase
    return lv;
  endfunction

  // Falling ramp: (HOLD * r + 7) / 15 for r of 1..14
  function automatic logic [LEVEL_W-1:0] ramp_down_level(input logic [3:0] r);
    logic [LEVEL_W-1:0] lv;
    unique case (r)
      4'd1:    lv = 16'd3932;
      4'd2:    lv = 16'd7864;
      4'd3:    lv = 16'd11796;
      4'd4:    lv = 16'd15729;
      4'd5:    lv = 16'd19661;
      4'd6:    lv = 16'd23593;
      4'd7:    lv = 16'd27525;
      4'd8:    lv = 16'd31457;
      4'd9:    lv = 16'd35389;
      4'd10:   lv = 16'd39321;
      4'd11:   lv = 16'd43253;
      4'd12:   lv = 16'd47186;
      4'd13:   lv = 16'd51118;
      4'd14:   lv = 16'd55050;
      default: lv = '0;
    endcase
    return lv;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ctpg_ctrl.sv =====
`default_nettype none

module ctpg_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire ctpg_pkg::ctpg_status_t status,
  output ctpg_pkg::ctpg_cmd_t        cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    EXECUTE
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    in_stall = (state != IDLE);
    cmd.load = (state == IDLE) && in_valid;
    cmd.step = (state == DIVIDE);
    cmd.exec = (state == EXECUTE) && (!out_valid || !out_stall);
  end

  // Advance the sequencer and hold the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) state <= DIVIDE;
        end
        DIVIDE: begin
          if (status.div_last) state <= EXECUTE;
        end
        EXECUTE: begin
          if (cmd.exec) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ctpg_datapath.sv =====
`default_nettype none

module ctpg_datapath #(
  parameter int POSITION_FRAC_BITS = 24,
  parameter int GAP_COUNTER_WIDTH  = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire ctpg_pkg::ctpg_cmd_t                    cmd,
  output ctpg_pkg::ctpg_status_t                      status,
  input  wire logic                                   cfg_write,
  input  wire logic [ctpg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ctpg_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                   playing_ok,
  input  wire logic                                   position_jump,
  input  wire logic signed [ctpg_pkg::TICK_W-1:0]     tick_position,
  input  wire logic signed [ctpg_pkg::TICK_W-1:0]     ticks_from_bar,
  input  wire logic [ctpg_pkg::TPS_W-1:0]             ticks_per_sample,
  input  wire logic [ctpg_pkg::BPB_W-1:0]             bar_beats,
  input  wire logic                                   eighth_signature,
  output logic [ctpg_pkg::LEVEL_W-1:0]                pulse_level,
  output logic                                        tick_started
);

  localparam int F    = POSITION_FRAC_BITS;
  localparam int G    = GAP_COUNTER_WIDTH;
  localparam int TW   = ctpg_pkg::TICK_W;
  localparam int QW   = TW - F;                 // whole-tick bits of the bar offset
  localparam int CNTW = $clog2(QW + 1);
  localparam int MW   = ctpg_pkg::MOD_W;
  localparam int EW0  = ctpg_pkg::ERR_W;
  localparam int RW   = MW + F;                 // full remainder, fraction included
  localparam int EW   = (RW > EW0) ? RW : EW0;
  localparam int FW   = (F > EW0) ? F : EW0;
  localparam int NW   = ctpg_pkg::TICKNUM_W;
  localparam int CUW  = (QW > NW) ? QW : NW;
  localparam int GW   = ctpg_pkg::GAPCFG_W;
  localparam int CW   = (G > GW) ? G : GW;
  localparam int LW   = ctpg_pkg::LEN_W;
  localparam int LVW  = ctpg_pkg::LEVEL_W;

  // Configuration
  logic [LW-1:0] pulse_length;
  logic [GW-1:0] min_gap;
  logic [GW-1:0] max_gap;

  // Persistent state
  logic          sync_started;
  logic          pulse_active;
  logic [LW-1:0] pulse_index;
  logic          last_valid;
  logic [NW-1:0] last_number;
  logic [G-1:0]  samples;

  // Latched request
  logic                  playing_q;
  logic                  jump_q;
  logic [TW-1:0]         pos_q;
  logic                  bar_neg_q;
  logic [F-1:0]          bar_frac_q;
  logic [ctpg_pkg::TPS_W-1:0] tps_q;
  logic [ctpg_pkg::BPB_W-1:0] bpb_q;
  logic                  eighth_q;
  logic [MW-1:0]         dvsr_q;

  // Remainder unit
  logic [QW-1:0]   quo_sh;
  logic [MW-1:0]   rem;
  logic [CNTW-1:0] div_count;
  logic [MW:0]     trial;
  logic [TW-1:0]   bar_mag;

  // Decision signals
  logic              pos_ok;
  logic [QW-1:0]     cur;
  logic [F-1:0]      frac;
  logic [F-1:0]      half;
  logic [F-1:0]      frac_off;
  logic [RW-1:0]     rem_full;
  logic [EW0-1:0]    err_v;
  logic              bar_hit;
  logic              sync_set;
  logic              sync_now;
  logic              valid_a;
  logic [G-1:0]      gap_a;
  logic [G-1:0]      gap_b;
  logic [G-1:0]      gap_c;
  logic [CW-1:0]     max_ext;
  logic [CW-1:0]     gap_lim;
  logic [CW-1:0]     max_sat;
  logic [CUW-1:0]    cur_ext;
  logic [CUW-1:0]    last_ext;
  logic              cur_gt;
  logic              half_hit;
  logic              first_hit;
  logic              want;
  logic              extra;
  logic              consider;
  logic              fire;
  logic [NW-1:0]     number_next;
  logic              act_b;
  logic [LW-1:0]     idx_b;
  logic [LW-1:0]     idx_n;
  logic [LW-1:0]     left;
  logic              act_c;
  logic [LW-1:0]     idx_c;
  logic [LVW-1:0]    level;

  assign bar_mag         = ticks_from_bar[TW-1] ? (-ticks_from_bar) : ticks_from_bar;
  assign trial           = {rem, quo_sh[QW-1]};
  assign status.div_last = (div_count == CNTW'(1));

  // Latch the request and run the bit-serial remainder of whole ticks
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      playing_q  <= playing_ok;
      jump_q     <= position_jump;
      pos_q      <= tick_position;
      bar_neg_q  <= ticks_from_bar[TW-1];
      bar_frac_q <= bar_mag[F-1:0];
      tps_q      <= ticks_per_sample;
      bpb_q      <= bar_beats;
      eighth_q   <= eighth_signature;
      dvsr_q     <= MW'(bar_beats) * MW'(ctpg_pkg::TICKS_PER_QUARTER);
      quo_sh     <= bar_mag[TW-1:F];
      rem        <= '0;
      div_count  <= CNTW'(QW);
    end else if (cmd.step) begin
      if (trial >= {1'b0, dvsr_q}) begin
        rem <= MW'(trial - {1'b0, dvsr_q});
      end else begin
        rem <= trial[MW-1:0];
      end
      quo_sh    <= {quo_sh[QW-2:0], 1'b0};
      div_count <= div_count - CNTW'(1);
    end
  end

  // Bar start check
  always_comb begin
    pos_ok   = !pos_q[TW-1];
    err_v    = EW0'(tps_q) * EW0'(ctpg_pkg::ERROR_SAMPLES);
    rem_full = {rem, bar_frac_q};
    if (bar_neg_q) begin
      bar_hit = (rem_full != '0) || (err_v != '0);
    end else begin
      bar_hit = EW'(rem_full) < EW'(err_v);
    end
    bar_hit  = bar_hit && (bpb_q != '0);
    sync_set = playing_q && pos_ok && !sync_started && bar_hit;
    sync_now = sync_started || sync_set;
  end

  // Tick decision
  always_comb begin
    max_ext  = CW'(max_gap);
    gap_lim  = CW'({G{1'b1}});
    max_sat  = (max_ext > gap_lim) ? gap_lim : max_ext;
    valid_a  = last_valid && !(playing_q && jump_q) && !sync_set;
    gap_a    = sync_set ? max_sat[G-1:0] : samples;

    cur      = pos_q[TW-1:F];
    frac     = pos_q[F-1:0];
    half     = F'(1) << (F - 1);
    frac_off = frac - half;
    cur_ext  = CUW'(cur);
    last_ext = CUW'(last_number);
    cur_gt   = cur_ext > last_ext;
    half_hit = eighth_q && (cur_ext == last_ext) && frac[F-1] &&
               (FW'(frac_off) < FW'(err_v));
    first_hit = FW'(frac) < FW'(err_v);
    want     = valid_a ? (cur_gt || half_hit) : first_hit;
    extra    = valid_a && !cur_gt && half_hit;

    consider = playing_q && pos_ok && sync_now && !pulse_active;
    fire     = consider && ((want && (CW'(gap_a) >= CW'(min_gap))) ||
                            (CW'(gap_a) >= CW'(max_gap)));

    if (!fire) begin
      number_next = last_number;
    end else if (!valid_a) begin
      number_next = cur_ext[NW-1:0];
    end else if (extra) begin
      number_next = last_number;
    end else begin
      number_next = last_number + NW'(1);
    end

    gap_b = fire ? '0 : gap_a;
    act_b = pulse_active || fire;
    idx_b = fire ? '0 : pulse_index;
  end

  // Pulse shaping and gap count
  always_comb begin
    idx_n = idx_b + LW'(1);
    left  = pulse_length - idx_n;
    act_c = act_b;
    idx_c = idx_b;
    level = '0;
    if (act_b) begin
      idx_c = idx_n;
      if (idx_n < LW'(4)) begin
        level = ctpg_pkg::ramp_up_level(idx_n[1:0]);
      end else if (pulse_length <= idx_n) begin
        act_c = 1'b0;
        idx_c = '0;
      end else if (left < LW'(15)) begin
        level = ctpg_pkg::ramp_down_level(left[3:0]);
      end else begin
        level = ctpg_pkg::HOLD_LEVEL;
      end
    end
    gap_c = (playing_q && (gap_b != {G{1'b1}})) ? gap_b + G'(1) : gap_b;
  end

  // Commit state and configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_length <= ctpg_pkg::PULSE_LENGTH_RST;
      min_gap      <= ctpg_pkg::MIN_GAP_RST;
      max_gap      <= ctpg_pkg::MAX_GAP_RST;
      sync_started <= 1'b0;
      pulse_active <= 1'b0;
      pulse_index  <= '0;
      last_valid   <= 1'b0;
      last_number  <= '0;
      samples      <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ctpg_pkg::REG_PULSE_LENGTH: pulse_length <= cfg_data[LW-1:0];
          ctpg_pkg::REG_MIN_GAP:      min_gap      <= cfg_data[GW-1:0];
          ctpg_pkg::REG_MAX_GAP:      max_gap      <= cfg_data[GW-1:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        sync_started <= playing_q && sync_now;
        pulse_active <= act_c;
        pulse_index  <= idx_c;
        last_valid   <= fire || valid_a;
        last_number  <= number_next;
        samples      <= gap_c;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pulse_level  <= level;
      tick_started <= fire;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clock_tick_pulse_generator_unit.sv =====
// Channel  Direction  Handshake             Payload
// in       into       in_valid / in_stall   playing_ok, position_jump, tick_position,
//                                           ticks_from_bar, ticks_per_sample,
//                                           bar_beats, eighth_signature
// out      out of     out_valid / out_stall pulse_level, tick_started
// cfg      into       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request runs through the bit-serial remainder, which walks the whole-tick bits
// of the bar offset, then a commit step; no new request is taken until the commit is done.
// The commit step loads the result register; the next request is
// taken while it waits, and the commit step waits only while it is still full.
// Synchronous reset restores register defaults and clears sync, pulse and gap state.
// cfg_ready is always high; writes to an index beyond the register list are dropped.
`default_nettype none
`include "assert_macros.svh"

module clock_tick_pulse_generator_unit #(
  parameter int POSITION_FRAC_BITS = 24,
  parameter int GAP_COUNTER_WIDTH  = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                playing_ok,
  input  wire logic                                position_jump,
  input  wire logic signed [ctpg_pkg::TICK_W-1:0]  tick_position,
  input  wire logic signed [ctpg_pkg::TICK_W-1:0]  ticks_from_bar,
  input  wire logic [ctpg_pkg::TPS_W-1:0]          ticks_per_sample,
  input  wire logic [ctpg_pkg::BPB_W-1:0]          bar_beats,
  input  wire logic                                eighth_signature,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [ctpg_pkg::LEVEL_W-1:0]             pulse_level,
  output logic                                     tick_started,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ctpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ctpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ctpg_pkg::ctpg_cmd_t    cmd;
  ctpg_pkg::ctpg_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer
  ctpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Remainder unit, tick decision, pulse shaper and result register
  ctpg_datapath #(
    .POSITION_FRAC_BITS (POSITION_FRAC_BITS),
    .GAP_COUNTER_WIDTH  (GAP_COUNTER_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .playing_ok       (playing_ok),
    .position_jump    (position_jump),
    .tick_position    (tick_position),
    .ticks_from_bar   (ticks_from_bar),
    .ticks_per_sample (ticks_per_sample),
    .bar_beats        (bar_beats),
    .eighth_signature (eighth_signature),
    .pulse_level      (pulse_level),
    .tick_started     (tick_started)
  );

  // A taken request keeps the input side busy on the next clock
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "busy after accept")
  // Commit only into a free or draining result register
  `ASSERT_IMPLY(a_exec_slot_free, clk, rst, cmd.exec, !out_valid || !out_stall, "result overwritten")
  // A new tick always shows the first ramp step
  `ASSERT_IMPLY(a_tick_level, clk, rst, out_valid && tick_started, pulse_level != '0, "zero tick")
  // Loading and iterating never coincide
  `ASSERT_NEVER(a_load_step, clk, rst, cmd.load && cmd.step, "load during remainder")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ctpg_pkg::*;

  localparam int FRAC_BITS      = 24;
  localparam int QUIET_LIMIT    = 5000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int TAIL_CYCLES    = 64;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 95;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic                      playing;
    logic                      jump;
    logic signed [TICK_W-1:0]  pos;
    logic signed [TICK_W-1:0]  from_bar;
    logic [TPS_W-1:0]          tps;
    logic [BPB_W-1:0]          bpb;
    logic                      eighth;
  } clock_req_t;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic               started;
  } pulse_out_t;

  // Tracks transport sync, tick numbering and the pulse shape per sample
  class tick_scoreboard;
    logic [LEN_W-1:0]     pulse_len;
    logic [GAPCFG_W-1:0]  min_gap;
    logic [GAPCFG_W-1:0]  max_gap;
    bit                   synced;
    bit                   pulse_on;
    logic [7:0]           pulse_idx;
    bit                   tick_known;
    logic [TICKNUM_W-1:0] tick_num;
    logic [31:0]          gap_count;
    pulse_out_t           due_levels[$];
    int                   mismatches;

    function new();
      pulse_len  = PULSE_LENGTH_RST;
      min_gap    = MIN_GAP_RST;
      max_gap    = MAX_GAP_RST;
      synced     = 1'b0;
      pulse_on   = 1'b0;
      pulse_idx  = '0;
      tick_known = 1'b0;
      tick_num   = '0;
      gap_count  = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PULSE_LENGTH: pulse_len = data[LEN_W-1:0];
        REG_MIN_GAP:      min_gap   = data;
        REG_MAX_GAP:      max_gap   = data;
        default: ;
      endcase
    endfunction

    // Advance the pulse by one sample and return its level
    function logic [LEVEL_W-1:0] next_level();
      int unsigned hold;
      int unsigned left;
      hold = 32'(HOLD_LEVEL);
      if (!pulse_on) return '0;
      pulse_idx = pulse_idx + 8'd1;
      if (pulse_idx < 4) return LEVEL_W'((hold * 32'(pulse_idx) + 32'd2) / 32'd4);
      if (pulse_len <= pulse_idx) begin
        pulse_on  = 1'b0;
        pulse_idx = '0;
        return '0;
      end
      left = 32'(pulse_len - pulse_idx);
      if (left < 15) return LEVEL_W'((hold * left + 32'd7) / 32'd15);
      return HOLD_LEVEL;
    endfunction

    // Work out the output for one accepted request
    function void note_sample(clock_req_t rq);
      longint     window;
      longint     bar_len;
      longint     rem;
      logic [23:0] cur_tick;
      logic [23:0] frac;
      bit         want;
      bit         extra;
      pulse_out_t res;
      res.started = 1'b0;
      window = 64'sd20 * longint'(rq.tps);
      if (rq.playing) begin
        if (rq.jump) tick_known = 1'b0;
        if (!rq.pos[TICK_W-1]) begin
          // bar start check, remainder takes the sign of the offset
          if (!synced && rq.bpb != 0) begin
            bar_len = (longint'(rq.bpb) * TICKS_PER_QUARTER) <<< FRAC_BITS;
            rem = longint'(rq.from_bar) % bar_len;
            if (rem < window) begin
              synced     = 1'b1;
              gap_count  = {8'h00, max_gap};
              tick_known = 1'b0;
            end
          end
          if (synced && !pulse_on) begin
            cur_tick = rq.pos[TICK_W-1:FRAC_BITS];
            frac     = rq.pos[FRAC_BITS-1:0];
            want     = 1'b0;
            extra    = 1'b0;
            if (tick_known) begin
              if (cur_tick > tick_num) begin
                want = 1'b1;
              end else if (rq.eighth && cur_tick == tick_num && frac[23] &&
                           longint'(frac[22:0]) < window) begin
                want  = 1'b1;
                extra = 1'b1;
              end
            end else if (longint'(frac) < window) begin
              want = 1'b1;
            end
            // hold back below the minimum gap, force at the maximum gap
            if ((want && gap_count >= min_gap) || gap_count >= max_gap) begin
              if (!tick_known) begin
                tick_num   = cur_tick;
                tick_known = 1'b1;
              end else if (!extra) begin
                tick_num = tick_num + 1'b1;
              end
              gap_count   = '0;
              pulse_on    = 1'b1;
              pulse_idx   = '0;
              res.started = 1'b1;
            end
          end
        end
        res.level = next_level();
        if (gap_count != '1) gap_count = gap_count + 32'd1;
      end else begin
        synced    = 1'b0;
        res.level = next_level();
      end
      due_levels.push_back(res);
    endfunction

    function void check_sample(logic [LEVEL_W-1:0] level, logic started);
      pulse_out_t want;
      if (due_levels.size() == 0) begin
        $display("%0t: unexpected output level=%0d tick_started=%0d", $time, level, started);
        mismatches++;
        return;
      end
      want = due_levels.pop_front();
      if (level !== want.level) begin
        $display("%0t: pulse_level expected %0d got %0d", $time, want.level, level);
        mismatches++;
      end
      if (started !== want.started) begin
        $display("%0t: tick_started expected %0d got %0d", $time, want.started, started);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        playing_ok = 1'b0;
  logic                        position_jump = 1'b0;
  logic signed [TICK_W-1:0]    tick_position = '0;
  logic signed [TICK_W-1:0]    ticks_from_bar = '0;
  logic [TPS_W-1:0]            ticks_per_sample = '0;
  logic [BPB_W-1:0]            bar_beats = '0;
  logic                        eighth_signature = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [LEVEL_W-1:0]          pulse_level;
  logic                        tick_started;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  logic press_req = 1'b0;
  logic press_done = 1'b0;
  int   hold_left = 0;
  int   recv_stall_pct = 52;
  int   send_idle_pct = 16;
  int   quiet_cycles = 0;

  tick_scoreboard sb;

  // Transport being played back by the random part
  longint     song_pos;
  longint     song_bar;
  longint     song_bar_len;
  int         song_left = 0;
  logic [23:0] song_tps;
  logic [6:0]  song_bpb;
  logic        song_eighth;
  logic        song_playing;

  clock_tick_pulse_generator_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .playing_ok       (playing_ok),
    .position_jump    (position_jump),
    .tick_position    (tick_position),
    .ticks_from_bar   (ticks_from_bar),
    .ticks_per_sample (ticks_per_sample),
    .bar_beats        (bar_beats),
    .eighth_signature (eighth_signature),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pulse_level      (pulse_level),
    .tick_started     (tick_started),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  // Record register writes, check outputs, predict accepted requests
  always @(posedge clk) begin : monitor
    clock_req_t seen;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) sb.check_sample(pulse_level, tick_started);
      if (in_valid && !in_stall) begin
        seen.playing  = playing_ok;
        seen.jump     = position_jump;
        seen.pos      = tick_position;
        seen.from_bar = ticks_from_bar;
        seen.tps      = ticks_per_sample;
        seen.bpb      = bar_beats;
        seen.eighth   = eighth_signature;
        sb.note_sample(seen);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (press_req && !press_done) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_OFF_LEN;
      press_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic clock_req_t make_sample(bit playing, bit jump, longint pos, longint bar,
                                             logic [23:0] tps, logic [6:0] bpb, bit eighth);
    clock_req_t s;
    s.playing  = playing;
    s.jump     = jump;
    s.pos      = pos[TICK_W-1:0];
    s.from_bar = bar[TICK_W-1:0];
    s.tps      = tps;
    s.bpb      = bpb;
    s.eighth   = eighth;
    return s;
  endfunction

  // Offer one request, hold it until taken, then maybe idle
  task automatic send_sample(input clock_req_t s);
    in_valid         <= 1'b1;
    playing_ok       <= s.playing;
    position_jump    <= s.jump;
    tick_position    <= s.pos;
    ticks_from_bar   <= s.from_bar;
    ticks_per_sample <= s.tps;
    bar_beats        <= s.bpb;
    eighth_signature <= s.eighth;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted output has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.due_levels.size() != 0) @(posedge clk);
  endtask

  // Write all registers, the unused index too
  task automatic load_registers(input logic [23:0] len, input logic [23:0] mn,
                                input logic [23:0] mx);
    logic [CFG_DATA_W-1:0] vals[4];
    logic [CFG_IDX_W-1:0]  idxs[4];
    idxs = '{REG_PULSE_LENGTH, REG_MIN_GAP, REG_MAX_GAP, REG_SPARE};
    vals = '{len, mn, mx, CFG_DATA_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Build the next random request: mostly a running transport, some noise
  task automatic next_sample(output clock_req_t s);
    if (song_left == 0) begin
      song_left = $urandom_range(80, 10);
      case ($urandom_range(4))
        0, 1:    song_tps = 24'($urandom_range(24'hFFFFFF, 24'h200000));
        2:       song_tps = 24'($urandom_range(24'h200000, 24'h40000));
        3:       song_tps = 24'($urandom_range(24'h10000, 1));
        default: song_tps = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
      endcase
      case ($urandom_range(9))
        0:       song_bpb = 7'd0;
        1:       song_bpb = 7'd64;
        2:       song_bpb = 7'($urandom_range(127, 65));
        default: song_bpb = 7'($urandom_range(8, 1));
      endcase
      song_bar_len = (longint'(song_bpb == 0 ? 4 : song_bpb) * TICKS_PER_QUARTER) <<< FRAC_BITS;
      case ($urandom_range(3))
        0:       song_bar = longint'({$urandom, $urandom} >> 1) % song_bar_len;
        1:       song_bar = -longint'($urandom_range(3)) * song_tps;
        default: song_bar = song_bar_len - longint'($urandom_range(4)) * song_tps;
      endcase
      case ($urandom_range(4))
        0:       song_pos = (64'sd1 <<< 47) - 1 - longint'($urandom_range(30)) * song_tps;
        1:       song_pos = -longint'($urandom_range(30)) * song_tps;
        default: song_pos = longint'($urandom) << $urandom_range(12);
      endcase
      song_eighth  = 1'($urandom_range(1));
      song_playing = ($urandom_range(99) < 90);
    end
    song_left--;
    if ($urandom_range(99) < 12) begin
      s = make_sample(1'($urandom_range(1)), 1'($urandom_range(1)), {$urandom, $urandom},
                      {$urandom, $urandom}, 24'($urandom), 7'($urandom),
                      1'($urandom_range(1)));
    end else begin
      if ($urandom_range(99) < 4) song_playing = !song_playing;
      s.jump = ($urandom_range(99) < 4);
      if (s.jump) begin
        song_pos = song_pos + ((longint'($urandom_range(4000)) - 2000) <<< 20);
        song_bar = song_bar_len - longint'($urandom_range(3)) * song_tps;
      end
      s = make_sample(song_playing, s.jump, song_pos, song_bar, song_tps, song_bpb,
                      song_eighth);
      // advance the playhead while the transport runs
      if (song_playing) begin
        song_pos = song_pos + song_tps;
        song_bar = song_bar + song_tps;
        if (song_bar >= song_bar_len) song_bar = song_bar - song_bar_len;
      end
    end
  endtask

  initial begin
    clock_req_t s;
    int item_no;
    sb = new();
    item_no = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under reset register values
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample(1, 0, 48'h8000_0000_0000, 0, 24'h100000, 4, 0));
    send_sample(make_sample(1, 0, 0, 0, 24'h100000, 0, 0));
    send_sample(make_sample(1, 0, 64'sd100 <<< 24, 64'sd146 <<< 24, 24'h100000, 4, 0));
    send_sample(make_sample(1, 0, 64'sd100 <<< 24, 64'sd192 <<< 24, 24'h100000, 4, 0));
    for (int i = 1; i <= 4; i++) begin
      send_sample(make_sample(1, 0, (64'sd100 <<< 24) + i * 64'sh100000,
                              (64'sd192 <<< 24) + i * 64'sh100000, 24'h100000, 4, 1));
    end
    send_sample(make_sample(1, 1, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 24'hFFFFFF,
                            7'h7F, 1));
    send_sample(make_sample(0, 1, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000, 24'hFFFFFF,
                            7'h7F, 1));
    send_sample(make_sample(1, 0, 64'sd200 <<< 24, -5, 24'h0, 4, 0));
    send_sample(make_sample(1, 0, (64'sd300 <<< 24) + 24'h800000, 0, 24'h1000, 64, 1));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: ;
        1: load_registers(24'd8, 24'd1, 24'd1);
        2: load_registers(24'd2, 24'd2, 24'd40);
        3: load_registers(24'd12, 24'd3, 24'd30);
        4: load_registers(24'd255, 24'hFFFFFF, 24'hFFFFFF);
        5: load_registers(24'd0, 24'd0, 24'd0);
        6: load_registers(24'd10, 24'd50, 24'd8);
        7: load_registers(24'd16, 24'd1, 24'd12);
        default: load_registers(24'($urandom_range(40, 8)), 24'($urandom_range(10, 1)),
                                24'($urandom_range(60, 5)));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // switch idle pattern by overall progress
        if (item_no == 317) begin
          send_idle_pct = 52;
          recv_stall_pct <= 16;
        end else if (item_no == 634) begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        if (item_no == 150) press_req <= 1'b1;
        next_sample(s);
        send_sample(s);
        item_no++;
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.due_levels.size() != 0) begin
      $display("%0t: %0d expected outputs never arrived", $time, sb.due_levels.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
